// ===== sv/txcw_pkg.sv =====
// Shared definitions for the text console cursor writer.
// Holds screen geometry, character codes, the controller state type and the
// command/status structs between controller and datapath. No dependencies.
package txcw_pkg;

  // Screen geometry.
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  // Field and internal widths.
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  // Wide enough for (ROWS-1)*COLUMNS + COLUMNS-1 at the largest geometry.
  localparam int BASE_W = 12;
  // Remaining-write counter holds up to TAB_STOP.
  localparam int CNT_W  = 4;
  // Position of the cursor inside its tab stop, 0 .. TAB_STOP-1.
  localparam int PH_W   = 3;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7E;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd11;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  typedef struct packed {
    logic load_print;
    logic load_tab;
    logic do_cr;
    logic do_lf;
    logic emit;
  } txcw_cmd_t;

  typedef struct packed {
    logic out_free;
    logic remain_last;
  } txcw_status_t;

endpackage

// ===== sv/txcw_ctrl.sv =====
// Controller state machine for the text console cursor writer.
// Decodes the incoming byte and sequences cell writes; uses txcw_pkg.
module txcw_ctrl import txcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  input  logic [CHAR_W-1:0] char_code,
  output logic              char_stall,
  input  txcw_status_t      status,
  output txcw_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic accept;
    logic is_print;
    accept     = 1'b0;
    is_print   = char_code inside {[CHAR_FIRST:CHAR_LAST]};
    cmd        = '0;
    state_next = state;
    char_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        char_stall = 1'b0;
        accept     = char_valid;
        if (accept) begin
          if (is_print) begin
            cmd.load_print = 1'b1;
            state_next     = ST_EMIT;
          end else if (char_code == CHAR_TAB) begin
            cmd.load_tab = 1'b1;
            state_next   = ST_EMIT;
          end else if (char_code == CHAR_CR) begin
            cmd.do_cr = 1'b1;
          end else if (char_code == CHAR_LF) begin
            cmd.do_lf = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        // One cell write whenever the output register can take it.
        cmd.emit = status.out_free;
        if (status.out_free && status.remain_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/txcw_datapath.sv =====
// Datapath for the text console cursor writer: cursor, attribute register,
// write counter and the output register. Uses txcw_pkg.
module txcw_datapath import txcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  txcw_cmd_t         cmd,
  output txcw_status_t      status,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              color_we,
  input  logic [ATTR_W-1:0] color_data,
  output logic              cell_valid,
  input  logic              cell_stall,
  output logic [ADDR_W-1:0] cell_address,
  output logic [CHAR_W-1:0] cell_char,
  output logic [ATTR_W-1:0] cell_attr,
  output logic              last_write
);

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [BASE_W-1:0] row_base;  // row * COLUMNS, kept by addition
  logic [PH_W-1:0]   phase;     // col modulo TAB_STOP
  logic [ATTR_W-1:0] attr;
  logic [CNT_W-1:0]  remain;
  logic [CHAR_W-1:0] cur_char;

  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [BASE_W-1:0] row_base_next;
  logic [PH_W-1:0]   phase_next;

  logic              at_col_end;
  logic              at_row_end;
  logic              at_phase_end;
  logic [ROW_W-1:0]  row_wrap;
  logic [BASE_W-1:0] base_wrap;
  logic [BASE_W-1:0] addr_full;

  assign at_col_end   = (col == COL_W'(COLUMNS - 1));
  assign at_row_end   = (row == ROW_W'(ROWS - 1));
  assign at_phase_end = (phase == PH_W'(TAB_STOP - 1));
  assign row_wrap     = at_row_end ? '0 : row + ROW_W'(1);
  assign base_wrap    = at_row_end ? '0 : row_base + BASE_W'(COLUMNS);
  assign addr_full    = row_base + BASE_W'(col);

  assign status.out_free    = !cell_valid || !cell_stall;
  assign status.remain_last = (remain == CNT_W'(1));

  always_comb begin
    col_next      = col;
    row_next      = row;
    row_base_next = row_base;
    phase_next    = phase;
    if (cmd.do_cr) begin
      col_next   = '0;
      phase_next = '0;
    end else if (cmd.do_lf || (cmd.emit && at_col_end)) begin
      col_next      = '0;
      phase_next    = '0;
      row_next      = row_wrap;
      row_base_next = base_wrap;
    end else if (cmd.emit) begin
      col_next   = col + COL_W'(1);
      phase_next = at_phase_end ? '0 : phase + PH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      row_base   <= '0;
      phase      <= '0;
      attr       <= ATTR_RESET;
      cell_valid <= 1'b0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      row_base <= row_base_next;
      phase    <= phase_next;
      if (color_we) begin
        attr <= color_data;
      end
      if (cmd.emit) begin
        cell_valid <= 1'b1;
      end else if (!cell_stall) begin
        cell_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_print) begin
      cur_char <= char_code;
      remain   <= CNT_W'(1);
    end else if (cmd.load_tab) begin
      cur_char <= CHAR_SPACE;
      remain   <= CNT_W'(TAB_STOP) - CNT_W'(phase);
    end else if (cmd.emit) begin
      remain <= remain - CNT_W'(1);
    end
    if (cmd.emit) begin
      cell_address <= addr_full[ADDR_W-1:0];
      cell_char    <= cur_char;
      cell_attr    <= attr;
      last_write   <= status.remain_last;
    end
  end

endmodule

// ===== sv/text_console_cursor_writer.sv =====
// Top level of the text console cursor writer.
// Instantiates txcw_ctrl and txcw_datapath; uses txcw_pkg.
//
// The block turns a stream of character bytes into screen cell writes.
// Input channel: char_valid / char_stall / char_code; a transaction happens
// on a rising edge with char_valid high and char_stall low. Output channel:
// cell_valid / cell_stall with cell_address, cell_char, cell_attr and
// last_write; last_write marks the final cell write caused by one byte.
// The attribute register is written through text_color_valid / text_color
// with text_color_ready, which is always high; write it only while idle.
//
// A printable byte is accepted in ST_IDLE, which loads cur_char; in ST_EMIT
// its write is loaded into the output register once that register is free.
// A tab writes one space per cell up to the next tab stop (up to TAB_STOP
// writes). CR and LF only move the cursor and leave the input open. The rate
// is one cell write per cycle from the datapath, while the output is free.
//
// While cell_valid and cell_stall are high the output register holds its
// transaction and the write sequence pauses; char_stall stays high until every write of the
// current byte is loaded. Reset (rst, synchronous) puts the cursor at row 0,
// column 0, sets the attribute to 11 and empties the output register.
module text_console_cursor_writer import txcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  logic [CHAR_W-1:0] char_code,
  output logic              cell_valid,
  input  logic              cell_stall,
  output logic [ADDR_W-1:0] cell_address,
  output logic [CHAR_W-1:0] cell_char,
  output logic [ATTR_W-1:0] cell_attr,
  output logic              last_write,
  input  logic              text_color_valid,
  output logic              text_color_ready,
  input  logic [ATTR_W-1:0] text_color
);

  txcw_cmd_t    cmd;
  txcw_status_t status;

  // The attribute register accepts a write in any cycle.
  assign text_color_ready = 1'b1;

  txcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_code  (char_code),
    .char_stall (char_stall),
    .status     (status),
    .cmd        (cmd)
  );

  txcw_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .char_code    (char_code),
    .color_we     (text_color_valid && text_color_ready),
    .color_data   (text_color),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_address (cell_address),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .last_write   (last_write)
  );

endmodule

// ===== sv/txcw_checker.sv =====
// Port-level checker for the text console cursor writer, bound to the top.
// Uses txcw_pkg for character codes.
module txcw_checker import txcw_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              char_valid,
  input logic              char_stall,
  input logic [CHAR_W-1:0] char_code,
  input logic              cell_valid,
  input logic              cell_stall,
  input logic [ADDR_W-1:0] cell_address,
  input logic [CHAR_W-1:0] cell_char,
  input logic [ATTR_W-1:0] cell_attr,
  input logic              last_write
);

  // A stalled cell transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_stall |=> cell_valid && $stable(cell_address) &&
      $stable(cell_char) && $stable(cell_attr) && $stable(last_write))
    else $error("cell transaction changed while stalled");

  // An accepted printable byte always puts the input into a stall.
  a_print_busy: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && char_code >= CHAR_FIRST && char_code <= CHAR_LAST
      |=> char_stall)
    else $error("printable byte did not start a write");

  // Carriage return only moves the cursor, so the input stays open.
  a_cr_free: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && char_code == CHAR_CR |=> !char_stall)
    else $error("carriage return blocked the input");

  // While a byte still has writes to come, no new byte is taken.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !last_write |-> char_stall)
    else $error("input open in the middle of a write sequence");

endmodule

bind text_console_cursor_writer txcw_checker u_txcw_checker (.*);
